// ----- design/bwda_pkg.sv -----
// Shared types, widths and constants for the blink window drowsiness alert block.
`default_nettype none

package bwda_pkg;

   // Ring capacity, in cells of the shift chain.
   localparam int WINDOW_MAX = 256;

   // Fixed field widths.
   localparam int CLASS_W  = 2;
   localparam int WLEN_W   = 9;
   localparam int THR_W    = 8;
   localparam int LIM_W    = 8;
   localparam int COUNT_W  = 16;
   localparam int CONSEC_W = 10;

   // Derived widths.
   localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
   localparam int LEN_W      = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;
   localparam int TOTAL_BIAS = 180;
   localparam int TOTAL_W    = $clog2(TOTAL_BIAS + WINDOW_MAX + 1);
   localparam int RATIO_SHIFT = 8;
   localparam int PROD_W     = THR_W + TOTAL_W;

   // Stream payload widths, whole bytes.
   localparam int REQ_W = 8;
   localparam int RSP_W = 24;

   // Register reset values.
   localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET     = WLEN_W'(180);
   localparam logic [THR_W-1:0]  RATIO_THRESHOLD_RESET   = THR_W'(64);
   localparam logic [LIM_W-1:0]  CONSECUTIVE_LIMIT_RESET = LIM_W'(4);

   typedef logic [CLASS_W-1:0] class_type;

   localparam class_type CLASS_LONG = class_type'(2);

   typedef enum logic [1:0] {
      CSR_WINDOW_LENGTH     = 2'd0,
      CSR_RATIO_THRESHOLD   = 2'd1,
      CSR_CONSECUTIVE_LIMIT = 2'd2
   } csr_index_type;

   // Control shared by every cell of the chain.
   typedef struct packed {
      logic shift;      // a transaction enters the chain this cycle
      logic grow;       // the window is not full, so the tail marker moves along
      logic fill_zero;  // the chain is empty, so the newest cell becomes the tail
   } chain_ctrl_type;

endpackage

`default_nettype wire

// ----- design/bwda_cell.sv -----
// One cell of the blink class chain: a stored class and a tail marker.
`default_nettype none

module bwda_cell import bwda_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  chain_ctrl_type ctrl,
   input  class_type      prev_class,
   input  wire            prev_tail,
   output class_type      class_out,
   output logic           tail_out,
   output logic           long_hit
);

   class_type class_ff, class_in;
   logic      tail_ff, tail_in;

   // On a shift the class always moves one cell on. The tail marker moves with
   // it while the window grows and stays put when the oldest entry is dropped.
   always_comb begin
      class_in = class_ff;
      tail_in  = tail_ff;
      if (ctrl.shift) begin
         class_in = prev_class;
         if (ctrl.grow) begin
            tail_in = prev_tail;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= 1'b0;
      end else begin
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
   end

   assign class_out = class_ff;
   assign tail_out  = tail_ff;
   assign long_hit  = tail_ff & (class_ff == CLASS_LONG);

endmodule

`default_nettype wire

// ----- design/bwda_chain.sv -----
// Row of class cells that forms the sliding window, with the oldest-entry lookup.
`default_nettype none

module bwda_chain import bwda_pkg::*; (
   input  wire            clock,
   input  wire            reset,
   input  chain_ctrl_type ctrl,
   input  class_type      head_class,
   output logic           oldest_long,
   output logic           tail_any
);

   class_type               class_link [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]   tail_vec;
   logic [WINDOW_MAX-1:0]   hit_vec;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == 0) begin : g_head
         bwda_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_class (head_class),
            .prev_tail  (ctrl.fill_zero),
            .class_out  (class_link[i]),
            .tail_out   (tail_vec[i]),
            .long_hit   (hit_vec[i])
         );
      end else begin : g_body
         bwda_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_class (class_link[i-1]),
            .prev_tail  (tail_vec[i-1]),
            .class_out  (class_link[i]),
            .tail_out   (tail_vec[i]),
            .long_hit   (hit_vec[i])
         );
      end
   end

   // At most one cell carries the tail marker, so an OR picks its class.
   assign oldest_long = |hit_vec;
   assign tail_any    = |tail_vec;

   a_tail_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tail_vec))
      else $error("more than one cell marked as the window tail");

endmodule

`default_nettype wire

// ----- design/bwda_outbuf.sv -----
// Output register with a skid stage for the result stream.
`default_nettype none

module bwda_outbuf import bwda_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_ready,
   input  wire [RSP_W-1:0]  in_data,
   output logic             out_valid,
   input  wire              out_ready,
   output logic [RSP_W-1:0] out_data
);

   logic             out_valid_ff, out_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [RSP_W-1:0] out_data_ff, out_data_in;
   logic [RSP_W-1:0] skid_data_ff, skid_data_in;
   logic             push;

   assign in_ready = ~skid_valid_ff;
   assign push     = in_valid & in_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (~out_valid_ff | out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

// ----- design/blink_window_drowsiness_alert.sv -----
// Top level of the blink window drowsiness alert block.
`default_nettype none

// Channel   Direction  Transaction
// req_      in         one blink class per frame
// rsp_      out        alert flag and running alert count
// csr_      in         write of one configuration register
//
// One request transaction is taken per cycle while req_tready is high. Its
// result is computed in the cycle it is accepted and registered in the output buffer
// before it reaches rsp_. The window is a chain of WINDOW_MAX cells that shifts
// once per transaction; the oldest-entry lookup and ratio multiply are combinational.
// A two-entry output buffer lets the next request enter while a result waits;
// req_tready drops only when both entries are full.
// Reset is synchronous; the cell classes need no reset because only cells
// inside the filled window are ever looked at.

module blink_window_drowsiness_alert import bwda_pkg::*; (
   input  wire              clock,
   input  wire              reset,
   // Request stream.
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire [REQ_W-1:0]  req_tdata,   // [1:0] blink_class, rest zero
   // Result stream.
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [0] alert, [16:1] alert_count, rest zero
   // Configuration writes.
   input  wire              csr_valid,
   output logic             csr_ready,
   input  wire [1:0]        csr_index,
   input  wire [WLEN_W-1:0] csr_data
);

   // Configuration registers.
   logic [WLEN_W-1:0] window_length_ff, window_length_in;
   logic [THR_W-1:0]  ratio_threshold_ff, ratio_threshold_in;
   logic [LIM_W-1:0]  consecutive_limit_ff, consecutive_limit_in;

   // Window counters.
   logic [FILL_W-1:0]          fill_count_ff, fill_count_in;
   logic [FILL_W-1:0]          long_count_ff, long_count_in;
   logic signed [CONSEC_W-1:0] consec_ff, consec_in;
   logic [COUNT_W-1:0]         alert_total_ff, alert_total_in;

   localparam logic signed [CONSEC_W-1:0] CONSEC_MAX = {1'b0, {(CONSEC_W-1){1'b1}}};
   localparam logic signed [CONSEC_W-1:0] CONSEC_MIN = {1'b1, {(CONSEC_W-1){1'b0}}};

   logic                       accept;
   class_type                  req_class;
   logic                       is_long;
   logic [LEN_W-1:0]           wlen_ext;
   logic [LEN_W-1:0]           eff_len;
   logic                       drop;
   chain_ctrl_type             chain_ctrl;
   logic                       oldest_long;
   logic                       tail_any;
   logic                       expire_long;
   logic [FILL_W:0]            long_sum;
   logic [FILL_W:0]            long_next;
   logic signed [CONSEC_W-1:0] consec_step;
   logic [TOTAL_W-1:0]         total_new;
   logic [PROD_W-1:0]          ratio_lhs;
   logic [PROD_W-1:0]          ratio_rhs;
   logic                       ratio_hit;
   logic                       consec_hit;
   logic [1:0]                 alert_inc;
   logic [COUNT_W:0]           alert_sum;
   logic                       alert_flag;
   logic [RSP_W-1:0]           result_data;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid & req_tready;
   assign req_class = req_tdata[CLASS_W-1:0];
   assign is_long   = (req_class == CLASS_LONG);

   // Configuration writes; an index outside the register list is ignored.
   always_comb begin
      window_length_in     = window_length_ff;
      ratio_threshold_in   = ratio_threshold_ff;
      consecutive_limit_in = consecutive_limit_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH: begin
               window_length_in = csr_data;
            end
            CSR_RATIO_THRESHOLD: begin
               ratio_threshold_in = csr_data[THR_W-1:0];
            end
            CSR_CONSECUTIVE_LIMIT: begin
               consecutive_limit_in = csr_data[LIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A window length of zero acts as one and anything beyond the chain acts as
   // the full chain. The oldest entry leaves once the ring holds that many.
   always_comb begin
      wlen_ext = LEN_W'(window_length_ff);
      if (wlen_ext == '0) begin
         eff_len = LEN_W'(1);
      end else if (wlen_ext > LEN_W'(WINDOW_MAX)) begin
         eff_len = LEN_W'(WINDOW_MAX);
      end else begin
         eff_len = wlen_ext;
      end
   end

   assign drop = (LEN_W'(fill_count_ff) >= eff_len);

   assign chain_ctrl.shift     = accept;
   assign chain_ctrl.grow      = ~drop;
   assign chain_ctrl.fill_zero = (fill_count_ff == '0);

   bwda_chain u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (chain_ctrl),
      .head_class  (req_class),
      .oldest_long (oldest_long),
      .tail_any    (tail_any)
   );

   assign expire_long = drop & oldest_long;

   // Long count: the new class enters, then an expiring long blink leaves.
   always_comb begin
      long_sum = {1'b0, long_count_ff} + (FILL_W+1)'(is_long);
      if (expire_long && (long_sum != '0)) begin
         long_next = long_sum - (FILL_W+1)'(1);
      end else begin
         long_next = long_sum;
      end
      long_count_in = long_next[FILL_W-1:0];
   end

   assign fill_count_in = drop ? fill_count_ff : fill_count_ff + FILL_W'(1);

   // Consecutive count: a long blink counts up, anything else clears it. An
   // expiring long blink then counts it down. Both ends saturate.
   always_comb begin
      if (is_long) begin
         if (consec_ff == CONSEC_MAX) begin
            consec_step = CONSEC_MAX;
         end else begin
            consec_step = consec_ff + CONSEC_W'(1);
         end
      end else begin
         consec_step = '0;
      end
      if (expire_long && (consec_step != CONSEC_MIN)) begin
         consec_in = consec_step - CONSEC_W'(1);
      end else begin
         consec_in = consec_step;
      end
   end

   // The total is the fill plus the fixed bias, so it follows the fill count.
   assign total_new = TOTAL_W'(TOTAL_BIAS) + TOTAL_W'(fill_count_in);

   assign ratio_lhs = PROD_W'({long_count_in, {RATIO_SHIFT{1'b0}}});
   assign ratio_rhs = PROD_W'(ratio_threshold_ff) * PROD_W'(total_new);
   assign ratio_hit = (ratio_lhs > ratio_rhs);

   assign consec_hit = (consec_in >= $signed({{(CONSEC_W-LIM_W){1'b0}},
                                              consecutive_limit_ff}));

   // Each condition that holds bumps the saturating alert count.
   always_comb begin
      alert_inc = {1'b0, ratio_hit} + {1'b0, consec_hit};
      alert_sum = {1'b0, alert_total_ff} + (COUNT_W+1)'(alert_inc);
      if (alert_sum[COUNT_W]) begin
         alert_total_in = {COUNT_W{1'b1}};
      end else begin
         alert_total_in = alert_sum[COUNT_W-1:0];
      end
   end

   assign alert_flag  = ratio_hit | consec_hit;
   assign result_data = {{(RSP_W-COUNT_W-1){1'b0}}, alert_total_in, alert_flag};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff     <= WINDOW_LENGTH_RESET;
         ratio_threshold_ff   <= RATIO_THRESHOLD_RESET;
         consecutive_limit_ff <= CONSECUTIVE_LIMIT_RESET;
         fill_count_ff        <= '0;
         long_count_ff        <= '0;
         consec_ff            <= '0;
         alert_total_ff       <= '0;
      end else begin
         window_length_ff     <= window_length_in;
         ratio_threshold_ff   <= ratio_threshold_in;
         consecutive_limit_ff <= consecutive_limit_in;
         if (accept) begin
            fill_count_ff  <= fill_count_in;
            long_count_ff  <= long_count_in;
            consec_ff      <= consec_in;
            alert_total_ff <= alert_total_in;
         end
      end
   end

   bwda_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // The ring never holds more entries than the chain has cells.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(WINDOW_MAX))
      else $error("fill count beyond the chain length");

   // Long blinks in the window never outnumber the entries.
   a_long_bound: assert property (@(posedge clock) disable iff (reset)
      long_count_ff <= fill_count_ff)
      else $error("long count exceeds the window fill");

   // The chain has a tail marker exactly when the window holds entries.
   a_tail_fill: assert property (@(posedge clock) disable iff (reset)
      tail_any == (fill_count_ff != '0))
      else $error("tail marker disagrees with the fill count");

   // The alert count never falls across a transaction.
   a_alert_mono: assert property (@(posedge clock) disable iff (reset)
      accept |=> alert_total_ff >= $past(alert_total_ff))
      else $error("alert count decreased");

endmodule

`default_nettype wire
